// File: design/linear_fade_level_ramp_defines.svh
// Assertion macros shared by the fade ramp RTL files.
`ifndef LINEAR_FADE_LEVEL_RAMP_DEFINES_SVH
`define LINEAR_FADE_LEVEL_RAMP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LFLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LFLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lflr_pkg.sv
// Shared types, constants and helpers for the fade level ramp.
package lflr_pkg;

    localparam int LVL_W   = 10;
    localparam int DELTA_W = LVL_W + 1;
    localparam int NOW_W   = 32;
    localparam int MODE_W  = 2;
    localparam int TGT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int QUO_W   = 2 * LVL_W;
    localparam int SUM_W   = QUO_W + 2;

    localparam int TIME_WIDTH_DEF     = 32;
    localparam int INTERVAL_WIDTH_DEF = 16;

    localparam logic [LVL_W-1:0] LVL_MAX        = '1;
    localparam logic [LVL_W-1:0] LVL_BLACK_RST  = LVL_W'(0);
    localparam logic [LVL_W-1:0] LVL_NORMAL_RST = LVL_W'(255);
    localparam logic [LVL_W-1:0] LVL_WHITE_RST  = LVL_W'(510);

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BLACK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_NORMAL = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WHITE  = CFG_IDX_W'(2);

    localparam logic [TGT_W-1:0] TGT_BLACK   = TGT_W'(0);
    localparam logic [TGT_W-1:0] TGT_NORMAL  = TGT_W'(1);
    localparam logic [TGT_W-1:0] TGT_WHITE   = TGT_W'(2);
    localparam logic [TGT_W-1:0] TGT_INVALID = TGT_W'(3);

    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 2'd0,
        MODE_START  = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CLAMP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // Clamp a signed sum into the legal level range.
    function automatic logic [LVL_W-1:0] sat_level(input logic signed [SUM_W-1:0] v);
        logic [LVL_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(SUM_W'(LVL_MAX)))
            r = LVL_MAX;
        else
            r = v[LVL_W-1:0];
        return r;
    endfunction

endpackage

// File: design/lflr_div.sv
// Restoring serial divider, one quotient bit per cycle.
`include "linear_fade_level_ramp_defines.svh"

module lflr_div #(
    parameter int DIVISOR_WIDTH = lflr_pkg::INTERVAL_WIDTH_DEF - 1
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [DIVISOR_WIDTH+lflr_pkg::QUO_W-1:0]   dividend,
    input  logic [DIVISOR_WIDTH-1:0]                   divisor,
    output logic [lflr_pkg::QUO_W-1:0]                 quotient,
    output logic                                       done
);
    import lflr_pkg::*;

    localparam int DVW   = DIVISOR_WIDTH;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DVW-1:0]   rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [DVW-1:0]   divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVW:0]     shifted;
    logic [DVW+1:0]   trial;
    logic             ge;

    // Upper dividend bits are below the divisor, so the remainder fits DVW bits.
    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor_reg};
    assign ge      = !trial[DVW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= dividend[DVW+QUO_W-1:QUO_W];
            quo_reg     <= dividend[QUO_W-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[DVW-1:0] : shifted[DVW-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `LFLR_ASSERT_NOW(a_no_restart, start, !busy_reg, "divider restarted while busy")
    `LFLR_ASSERT_NOW(a_rem_below_divisor, busy_reg, rem_reg < divisor_reg,
        "partial remainder not below divisor")
    `LFLR_ASSERT_NEXT(a_done_after_last, busy_reg && (cnt_reg == CNT_W'(1)), done_reg,
        "missing done after last quotient bit")

endmodule

// File: design/linear_fade_level_ramp.sv
// Fade level ramp: one pending linear ramp between intensity levels, serial divide.
//
// Each transfer on the input channel is one command: read the current level,
// start a fade to black/normal/white, or flush the pending fade. A read while
// a ramp is pending returns base + delta*elapsed/interval (truncated toward
// zero, saturated to 0..1023), where elapsed is now - ramp start taken as a
// signed TIME_WIDTH-bit value and clamped above to the interval; the read
// that sees the ramp over commits the end level. Every command yields exactly
// one result transfer. A read with a pending ramp passes through subtract,
// clamp and multiply steps, 20 restoring divider steps producing one quotient
// bit each and the divider done flag, then the output load; every other
// command goes straight to the output load. The load waits while the output
// register is full and not being read. in_ready returns the cycle after the
// result is loaded. One command is in flight at a time; in_ready
// is high whenever the sequencer is idle, even while a result still waits in
// the output register. Level registers are written through cfg_we/cfg_index/
// cfg_wdata and should only be changed while no command is in flight.
`include "linear_fade_level_ramp_defines.svh"

module linear_fade_level_ramp #(
    parameter int TIME_WIDTH     = lflr_pkg::TIME_WIDTH_DEF,
    parameter int INTERVAL_WIDTH = lflr_pkg::INTERVAL_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lflr_pkg::MODE_W-1:0]        mode,
    input  logic [lflr_pkg::TGT_W-1:0]         fade_target,
    input  logic signed [INTERVAL_WIDTH-1:0]   interval,
    input  logic [lflr_pkg::NOW_W-1:0]         now,
    input  logic                               quit_request,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lflr_pkg::LVL_W-1:0]         level,
    output logic [lflr_pkg::NOW_W-1:0]         timeout,
    output logic                               fade_pending,
    // level register writes
    input  logic                               cfg_we,
    input  logic [lflr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lflr_pkg::LVL_W-1:0]         cfg_wdata
);
    import lflr_pkg::*;

    localparam int TW    = TIME_WIDTH;
    localparam int IW    = INTERVAL_WIDTH;
    localparam int DVW   = IW - 1;            // positive interval magnitude
    localparam int EW    = DVW + LVL_W;       // clamped elapsed magnitude
    localparam int PW    = DVW + QUO_W;       // product width
    localparam int CMP_W = (TW > EW) ? TW : EW;

    // sequencer
    state_t state_reg, state_next;
    logic   div_start;
    logic   load_out;

    // captured command
    mode_t            mode_reg;
    logic [TGT_W-1:0] tgt_reg;
    logic [IW-1:0]    iv_reg;
    logic [TW-1:0]    now_reg;
    logic             quit_reg;

    // level registers
    logic [LVL_W-1:0] lvl_black_reg;
    logic [LVL_W-1:0] lvl_normal_reg;
    logic [LVL_W-1:0] lvl_white_reg;

    // ramp state; len_reg == 0 means no ramp pending
    logic [LVL_W-1:0]          base_reg,  base_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic [TW-1:0]             start_reg, start_next;
    logic [IW-1:0]             len_reg,   len_next;

    // read datapath
    logic [TW-1:0]    diff_reg;
    logic [TW-1:0]    negd_reg;
    logic [EW-1:0]    emag_reg;
    logic             prod_neg_reg;
    logic             commit_reg;
    logic [EW-1:0]    lim;
    logic             diff_neg;
    logic             commit_c;
    logic [EW-1:0]    emag_c;
    logic [LVL_W-1:0] dmag;
    logic [PW-1:0]    prod;
    logic [QUO_W-1:0] quo;
    logic             div_done;

    // result
    logic             out_valid_reg;
    logic [LVL_W-1:0] level_reg,   level_next;
    logic [NOW_W-1:0] timeout_reg, timeout_next;
    logic             pending_reg;

    // ---------------------------------------------------------------
    // Level registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_black_reg  <= LVL_BLACK_RST;
            lvl_normal_reg <= LVL_NORMAL_RST;
            lvl_white_reg  <= LVL_WHITE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEVEL_BLACK:  lvl_black_reg  <= cfg_wdata;
                REG_LEVEL_NORMAL: lvl_normal_reg <= cfg_wdata;
                REG_LEVEL_WHITE:  lvl_white_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // only a read during a ramp needs the divider
                    if ((mode == MODE_READ) && (len_reg != '0))
                        state_next = ST_DIFF;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_DIFF:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_MUL;
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode_t'(mode);
            tgt_reg  <= fade_target;
            iv_reg   <= interval;
            now_reg  <= TW'(now);
            quit_reg <= quit_request;
        end
    end

    // ---------------------------------------------------------------
    // Elapsed time, clamp and multiply
    // ---------------------------------------------------------------
    // Backward elapsed is clamped at 1024 intervals: any |delta| >= 1 then
    // already gives a quotient of 1024 or more, which saturates the level.
    assign lim      = {len_reg[DVW-1:0], {LVL_W{1'b0}}};
    assign diff_neg = diff_reg[TW-1];

    always_comb
    begin
        commit_c = 1'b0;
        emag_c   = '0;
        if (diff_neg)
        begin
            emag_c = (CMP_W'(negd_reg) < CMP_W'(lim)) ? EW'(negd_reg) : lim;
        end
        else
        begin
            commit_c = CMP_W'(diff_reg) >= CMP_W'(len_reg);
            emag_c   = commit_c ? EW'(len_reg) : EW'(diff_reg);
        end
    end

    assign dmag = delta_reg[DELTA_W-1] ? LVL_W'(-delta_reg) : LVL_W'(delta_reg);
    assign prod = PW'(dmag) * PW'(emag_reg);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DIFF:
            begin
                diff_reg <= now_reg - start_reg;
                negd_reg <= start_reg - now_reg;
            end
            ST_CLAMP:
            begin
                emag_reg     <= emag_c;
                commit_reg   <= commit_c;
                prod_neg_reg <= diff_neg ^ delta_reg[DELTA_W-1];
            end
            default: ;
        endcase
    end

    // product feeds the divider registers directly
    lflr_div #(
        .DIVISOR_WIDTH (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (len_reg[DVW-1:0]),
        .quotient (quo),
        .done     (div_done)
    );

    // ---------------------------------------------------------------
    // Command completion: next ramp state and result
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] base_s;
    logic signed [SUM_W-1:0] quo_s;
    logic [LVL_W-1:0]        rd_level;
    logic [LVL_W-1:0]        fin_base;
    logic [LVL_W-1:0]        end_lvl;
    logic                    immediate;
    logic                    ramp_on;

    assign base_s    = $signed(SUM_W'(base_reg));
    assign quo_s     = $signed(SUM_W'(quo));
    assign rd_level  = sat_level(prod_neg_reg ? (base_s - quo_s) : (base_s + quo_s));
    assign ramp_on   = len_reg != '0;
    // finishing a pending ramp lands on base + delta
    assign fin_base  = ramp_on ? sat_level(base_s + SUM_W'(delta_reg)) : base_reg;
    assign immediate = quit_reg || (iv_reg == '0) || iv_reg[IW-1];

    always_comb
    begin
        case (tgt_reg)
            TGT_BLACK:  end_lvl = lvl_black_reg;
            TGT_NORMAL: end_lvl = lvl_normal_reg;
            TGT_WHITE:  end_lvl = lvl_white_reg;
            default:    end_lvl = base_reg;
        endcase
    end

    always_comb
    begin
        base_next    = base_reg;
        delta_next   = delta_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        level_next   = base_reg;
        timeout_next = '0;
        case (mode_reg)
            MODE_READ:
            begin
                if (ramp_on)
                begin
                    level_next = rd_level;
                    if (commit_reg)
                    begin
                        base_next = rd_level;
                        len_next  = '0;
                    end
                end
            end
            MODE_START:
            begin
                if (tgt_reg == TGT_INVALID)
                begin
                    timeout_next = NOW_W'(now_reg);
                end
                else if (immediate)
                begin
                    base_next    = end_lvl;
                    len_next     = '0;
                    level_next   = end_lvl;
                    timeout_next = NOW_W'(now_reg);
                end
                else
                begin
                    base_next    = fin_base;
                    len_next     = iv_reg;
                    delta_next   = $signed({1'b0, end_lvl}) - $signed({1'b0, fin_base});
                    start_next   = now_reg;
                    level_next   = fin_base;
                    timeout_next = NOW_W'(now_reg + TW'(iv_reg) + TW'(1));
                end
            end
            MODE_FLUSH:
            begin
                base_next  = fin_base;
                len_next   = '0;
                level_next = fin_base;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= LVL_NORMAL_RST;
            delta_reg     <= '0;
            start_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                base_reg      <= base_next;
                delta_reg     <= delta_next;
                start_reg     <= start_next;
                len_reg       <= len_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            level_reg   <= level_next;
            timeout_reg <= timeout_next;
            pending_reg <= len_next != '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign level        = level_reg;
    assign timeout      = timeout_reg;
    assign fade_pending = pending_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `LFLR_ASSERT_NOW(a_result_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE),
        "result appeared outside completion")
    `LFLR_ASSERT_NOW(a_len_positive, len_reg != '0, !len_reg[IW-1],
        "pending ramp length is negative")
    `LFLR_ASSERT_NEXT(a_div_to_done, (state_reg == ST_DIV) && div_done, state_reg == ST_DONE,
        "divider finish did not reach completion")
    `LFLR_ASSERT_NEXT(a_base_held, state_reg != ST_DONE, $stable(base_reg),
        "committed level changed outside completion")

endmodule

// File: tb/tb_linear_fade_level_ramp.sv
// Self-checking testbench for the fade level ramp: directed and random commands, scoreboard.
`timescale 1ns / 100ps

module tb_linear_fade_level_ramp;
    import lflr_pkg::*;

    localparam int IV_W       = INTERVAL_WIDTH_DEF;
    localparam int CYCLE_CAP  = 400000;  // generous run limit
    localparam int LONG_STALL = 400;     // receiver hold-off, long enough to back up the input
    localparam int PHASE_LEN  = 125;     // random commands per register setting

    // One command as presented on the input channel.
    typedef struct {
        mode_t                  mode;
        logic [TGT_W-1:0]       target;
        logic signed [IV_W-1:0] interval;
        logic [NOW_W-1:0]       now;
        logic                   quit;
    } fade_cmd_t;

    // One result transfer.
    typedef struct {
        logic [LVL_W-1:0] level;
        logic [NOW_W-1:0] timeout;
        logic             pending;
    } fade_res_t;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // DUT inputs: all start at known values.
    logic                   in_valid     = 1'b0;
    logic [MODE_W-1:0]      mode         = '0;
    logic [TGT_W-1:0]       fade_target  = '0;
    logic signed [IV_W-1:0] interval     = '0;
    logic [NOW_W-1:0]       now          = '0;
    logic                   quit_request = 1'b0;
    logic                   out_ready    = 1'b0;
    logic                   cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [LVL_W-1:0]       cfg_wdata    = '0;

    // DUT outputs.
    logic             in_ready;
    logic             out_valid;
    logic [LVL_W-1:0] level;
    logic [NOW_W-1:0] timeout;
    logic             fade_pending;

    // Commands waiting to be driven, and results owed by the DUT.
    fade_cmd_t cmd_q[$];
    fade_res_t owed_q[$];
    int        err_count = 0;

    // Shadow copy of the level registers.
    logic [LVL_W-1:0] lvl_black  = LVL_BLACK_RST;
    logic [LVL_W-1:0] lvl_normal = LVL_NORMAL_RST;
    logic [LVL_W-1:0] lvl_white  = LVL_WHITE_RST;

    // Shadow copy of the ramp state.
    logic [LVL_W-1:0]         sh_base   = LVL_NORMAL_RST;
    logic signed [DELTA_W-1:0] sh_delta = '0;
    logic [NOW_W-1:0]         sh_start  = '0;
    logic [IV_W-1:0]          sh_len    = '0;   // 0: no ramp pending

    // Time base used to build coherent command sequences.
    logic [NOW_W-1:0] seq_clock = 32'h0000_1000;

    // Long receiver hold-off, requested once by the stimulus.
    logic long_stall_req = 1'b0;
    int   long_stall_cnt = 0;
    logic long_stall_on;
    assign long_stall_on = long_stall_req && (long_stall_cnt < LONG_STALL);

    linear_fade_level_ramp DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .fade_target  (fade_target),
        .interval     (interval),
        .now          (now),
        .quit_request (quit_request),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .level        (level),
        .timeout      (timeout),
        .fade_pending (fade_pending),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Level prediction
    // ------------------------------------------------------------------

    function automatic logic [LVL_W-1:0] clamp_level(input longint v);
        logic [LVL_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > 1023)
            r = LVL_MAX;
        else
            r = v[LVL_W-1:0];
        return r;
    endfunction

    // Commit the end level of a pending ramp.
    function automatic void close_ramp();
        if (sh_len != 0)
        begin
            sh_base = clamp_level(longint'(sh_base) + longint'(sh_delta));
            sh_len  = '0;
        end
    endfunction

    // Apply one command to the shadow state and return the level/timeout it yields.
    function automatic fade_res_t predict_fade(input fade_cmd_t c);
        fade_res_t        r;
        logic [NOW_W-1:0] diff;
        longint           elapsed;
        longint           span;
        logic [LVL_W-1:0] end_lvl;
        bit               immediate;

        r.timeout = '0;
        case (c.mode)
            MODE_READ:
            begin
                if (sh_len != 0)
                begin
                    diff = c.now - sh_start;
                    span = longint'(sh_len);
                    // signed difference, clamped above only
                    if (diff[NOW_W-1])
                        elapsed = longint'($signed(diff));
                    else if (longint'(diff) > span)
                        elapsed = span;
                    else
                        elapsed = longint'(diff);
                    // SV signed division truncates toward zero
                    r.level = clamp_level(longint'(sh_base) +
                                          (longint'(sh_delta) * elapsed) / span);
                    if (elapsed >= span)
                    begin
                        sh_base = r.level;
                        sh_len  = '0;
                    end
                end
                else
                    r.level = sh_base;
            end
            MODE_START:
            begin
                if (c.target == TGT_INVALID)
                    r.timeout = c.now;   // no state change
                else
                begin
                    case (c.target)
                        TGT_BLACK:  end_lvl = lvl_black;
                        TGT_NORMAL: end_lvl = lvl_normal;
                        default:    end_lvl = lvl_white;
                    endcase
                    immediate = c.quit || (c.interval <= 0);
                    close_ramp();
                    if (immediate)
                    begin
                        sh_base   = end_lvl;
                        sh_len    = '0;
                        r.timeout = c.now;
                    end
                    else
                    begin
                        sh_len    = c.interval;
                        sh_delta  = DELTA_W'(int'(end_lvl) - int'(sh_base));
                        sh_start  = c.now;
                        r.timeout = c.now + {{(NOW_W-IV_W){1'b0}}, c.interval} + 32'd1;
                    end
                end
                r.level = sh_base;
            end
            MODE_FLUSH:
            begin
                close_ramp();
                r.level = sh_base;
            end
            default:
                r.level = sh_base;
        endcase
        r.pending = (sh_len != 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps
    // ------------------------------------------------------------------

    fade_cmd_t drv_cmd;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                owed_q.push_back(predict_fade(drv_cmd));

            // next item only once the current one has transferred
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    drv_cmd = cmd_q.pop_front();
                    mode         <= drv_cmd.mode;
                    fade_target  <= drv_cmd.target;
                    interval     <= drv_cmd.interval;
                    now          <= drv_cmd.now;
                    quit_request <= drv_cmd.quit;
                    in_valid     <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        // some bursts are long with no gap at all
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 10);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: receiver stall pattern and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [NOW_W-1:0] got,
                                   input logic [NOW_W-1:0] want);
        $display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    logic [15:0] ready_pat = 16'hFFFF;
    int          pat_age   = 0;
    fade_res_t   mon_want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                    report_mismatch("result transfer with none owed", {22'b0, level}, '0);
                else
                begin
                    mon_want = owed_q.pop_front();
                    if (level !== mon_want.level)
                        report_mismatch("level", {22'b0, level}, {22'b0, mon_want.level});
                    if (timeout !== mon_want.timeout)
                        report_mismatch("timeout", timeout, mon_want.timeout);
                    if (fade_pending !== mon_want.pending)
                        report_mismatch("fade_pending", {31'b0, fade_pending},
                                        {31'b0, mon_want.pending});
                end
            end

            // pick a fresh stall pattern each time the pat_age counter wraps
            pat_age++;
            if (pat_age == 64)
            begin
                pat_age = 0;
                case ($urandom_range(0, 3))
                    0:       ready_pat = 16'hFFFF;
                    1:       ready_pat = 16'($urandom);
                    2:       ready_pat = 16'($urandom | $urandom);
                    default: ready_pat = 16'($urandom & $urandom);
                endcase
                if (ready_pat == 0)
                    ready_pat[0] = 1'b1;
            end
            out_ready <= long_stall_on ? 1'b0 : ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
    end

    // Hold-off length counted here, independent of the stall pattern.
    always @(posedge clk)
    begin
        if (long_stall_req && long_stall_cnt < LONG_STALL)
            long_stall_cnt <= long_stall_cnt + 1;
    end

    // Run limit.
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("linear_fade_level_ramp verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic add_cmd(input mode_t m, input logic [TGT_W-1:0] t, input int iv,
                           input logic [NOW_W-1:0] n, input bit q);
        fade_cmd_t c;
        c.mode     = m;
        c.target   = t;
        c.interval = IV_W'(iv);
        c.now      = n;
        c.quit     = q;
        cmd_q.push_back(c);
    endtask

    // Level register write; the block is idle whenever this runs.
    task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_LEVEL_BLACK:  lvl_black  = val;
            REG_LEVEL_NORMAL: lvl_normal = val;
            REG_LEVEL_WHITE:  lvl_white  = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_levels(input logic [LVL_W-1:0] b, input logic [LVL_W-1:0] n,
                              input logic [LVL_W-1:0] w);
        write_level(REG_LEVEL_BLACK, b);
        write_level(REG_LEVEL_NORMAL, n);
        write_level(REG_LEVEL_WHITE, w);
    endtask

    // Wait until every queued command has transferred and every result is back.
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_q.size() != 0 || in_valid || owed_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Mostly start/read.../flush sequences around a common time base, some noise.
    task automatic gen_random(input int n_items);
        int               made;
        int               iv;
        int               nreads;
        int               k;
        logic [NOW_W-1:0] t0;
        logic [NOW_W-1:0] offs;
        made = 0;
        while (made < n_items)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                if ($urandom_range(0, 9) == 0)
                    seq_clock = $urandom;
                t0 = seq_clock;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: iv = $urandom_range(1, 40);
                    12, 13, 14, 15, 16:                   iv = $urandom_range(41, 2000);
                    default:                              iv = $urandom_range(2001, 32767);
                endcase
                // now and then an immediate start inside a sequence
                if ($urandom_range(0, 9) == 0)
                    add_cmd(MODE_START, TGT_W'($urandom_range(0, 2)), iv, t0, 1'b1);
                else
                    add_cmd(MODE_START, TGT_W'($urandom_range(0, 2)), iv, t0, 1'b0);
                made++;
                nreads = $urandom_range(1, 6);
                for (k = 0; k < nreads; k++)
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: offs = $urandom_range(0, iv);
                        10, 11, 12, 13:  offs = iv + $urandom_range(1, 1000);
                        14, 15, 16:      offs = -$urandom_range(1, 50);
                        17, 18:          offs = $urandom;
                        default:         offs = iv;
                    endcase
                    add_cmd(MODE_READ, TGT_W'($urandom_range(0, 3)), $urandom, t0 + offs,
                            1'($urandom_range(0, 1)));
                    made++;
                end
                if ($urandom_range(0, 9) < 3)
                begin
                    add_cmd(MODE_FLUSH, TGT_W'($urandom_range(0, 3)), $urandom, $urandom,
                            1'($urandom_range(0, 1)));
                    made++;
                end
                seq_clock = t0 + iv + $urandom_range(0, 100);
            end
            else
            begin
                add_cmd(mode_t'($urandom_range(0, 3)), TGT_W'($urandom_range(0, 3)), $urandom,
                        $urandom, 1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset register values.
        @(negedge clk);
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'h0000_0000, 1'b0); // read, nothing pending
        add_cmd(MODE_UNUSED, TGT_WHITE,   100,    32'hFFFF_FFFF, 1'b1); // unused mode
        add_cmd(MODE_START,  TGT_INVALID, 50,     32'd12345,     1'b0); // invalid target
        add_cmd(MODE_FLUSH,  TGT_BLACK,   0,      32'd12346,     1'b0); // flush, nothing pending
        add_cmd(MODE_START,  TGT_BLACK,   0,      32'd100,       1'b0); // zero interval
        add_cmd(MODE_START,  TGT_WHITE,   -32768, 32'd101,       1'b0); // negative interval
        add_cmd(MODE_START,  TGT_NORMAL,  100,    32'd102,       1'b1); // quit forces jump
        add_cmd(MODE_START,  TGT_WHITE,   100,    32'd1000,      1'b0); // ramp up
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd1050,      1'b0); // mid ramp
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd900,       1'b0); // before ramp start
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd1000 + 32'h8000_0000, 1'b0); // most negative
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd1100,      1'b0); // ramp end, commits
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd2000,      1'b0);
        add_cmd(MODE_START,  TGT_BLACK,   32767,  32'hFFFF_FFF0, 1'b0); // timeout wraps
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'h0000_0100, 1'b0); // across the wrap
        add_cmd(MODE_START,  TGT_NORMAL,  1,      32'd5,         1'b0); // start over a pending ramp
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd5,         1'b0); // zero elapsed
        add_cmd(MODE_FLUSH,  TGT_INVALID, -1,     32'd6,         1'b1);
        add_cmd(MODE_START,  TGT_WHITE,   7,      32'd0,         1'b0);
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd3,         1'b0); // truncation, rising
        add_cmd(MODE_START,  TGT_BLACK,   7,      32'd10,        1'b0);
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd13,        1'b0); // truncation, falling
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'hFFFF_FFFF, 1'b0); // negative elapsed, saturates
        add_cmd(MODE_READ,   TGT_BLACK,   0,      32'd17,        1'b0);
        add_cmd(MODE_START,  TGT_INVALID, 0,      32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // Extreme register values; the long receiver hold-off falls in this phase.
        set_levels(10'd1023, 10'd0, 10'd1023);
        @(negedge clk);
        gen_random(PHASE_LEN);
        long_stall_req = 1'b1;
        wait_drained();

        // A ramp may still be pending here: the new settings must not touch it.
        set_levels(10'd0, 10'd1023, 10'd0);
        @(negedge clk);
        gen_random(PHASE_LEN);
        wait_drained();

        set_levels(LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom));
        @(negedge clk);
        gen_random(PHASE_LEN);
        wait_drained();

        set_levels(LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom));
        @(negedge clk);
        gen_random(PHASE_LEN);
        wait_drained();

        if (err_count == 0 && owed_q.size() == 0)
            $display("linear_fade_level_ramp verification clean");
        else
            $display("linear_fade_level_ramp verification failed");
        $finish;
    end

endmodule
